// File: rtl/npp_pkg.sv
// Package for the Newell polygon plane unit: widths, status codes and the
// command and status records between the controller and the datapath.
// Used by every module of the block; depends on nothing.
package npp_pkg;

  localparam int COORD_W      = 24;
  localparam int ACC_W        = 58;
  localparam int SUM_W        = 33;
  localparam int CNT_W        = 9;
  localparam int MAX_VERTICES = 256;
  localparam int MIN_VERTICES = 3;
  localparam int UNIT_SHIFT   = 14;
  localparam int UNIT_ONE     = 16384;
  localparam int NORM_W       = 16;
  localparam int OFF_W        = 27;
  localparam int MUL_W        = 33;
  localparam int PROD_W       = 66;
  localparam int MAG_KEEP     = 31;
  localparam int SHIFT_W      = 5;
  localparam int SQ_W         = 64;
  localparam int ROOT_W       = 32;
  localparam int ROOT_CNT_W   = $clog2(ROOT_W);
  localparam int DIV_NUM_W    = 50;
  localparam int DIV_DEN_W    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);
  localparam int DOT_W        = 52;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int OFF_POS_MAX  = 67108863;
  localparam int OFF_NEG_MAG  = 67108864;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEN = 2'd0;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FEW   = 2'd1;
  localparam logic [1:0] STATUS_DEGEN = 2'd2;
  localparam logic [1:0] STATUS_MANY  = 2'd3;

  localparam logic [1:0] LAST_COMP = 2'd2;

  typedef struct packed {
    logic       take_init;
    logic       take_edge;
    logic       take_ovf;
    logic       acc_edge;
    logic       close_mul;
    logic       close_acc;
    logic       mag_load;
    logic       norm_step;
    logic       sq_mul;
    logic       sq_sum;
    logic       sqrt_start;
    logic       decide;
    logic       ndiv_start;
    logic       ndiv_store;
    logic       off_mul;
    logic       off_sum;
    logic       odiv_start;
    logic       off_store;
    logic       clear;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic edge_ok;
    logic norm_busy;
    logic sqrt_done;
    logic div_done;
    logic status_ok;
  } sts_t;

endpackage

// File: rtl/npp_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on npp_pkg for widths.
module npp_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [npp_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [npp_pkg::ROOT_W-1:0]  root
);

  logic [npp_pkg::SQ_W-1:0]       x;
  logic [npp_pkg::ROOT_W+2:0]     rem;
  logic [npp_pkg::ROOT_W+2:0]     rem_sh;
  logic [npp_pkg::ROOT_W+2:0]     trial;
  logic [npp_pkg::ROOT_CNT_W-1:0] cnt;
  logic                           busy;

  assign rem_sh = {rem[npp_pkg::ROOT_W:0], x[npp_pkg::SQ_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x <= {x[npp_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[npp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[npp_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == npp_pkg::ROOT_CNT_W'(npp_pkg::ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/npp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on npp_pkg for widths.
module npp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [npp_pkg::DIV_NUM_W-1:0] num,
  input  logic [npp_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [npp_pkg::DIV_NUM_W-1:0] quo
);

  logic [npp_pkg::DIV_NUM_W-1:0] n;
  logic [npp_pkg::DIV_DEN_W-1:0] d;
  logic [npp_pkg::DIV_DEN_W:0]   rem;
  logic [npp_pkg::DIV_DEN_W:0]   rem_sh;
  logic [npp_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;

  assign rem_sh = {rem[npp_pkg::DIV_DEN_W-1:0], n[npp_pkg::DIV_NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      n    <= num;
      d    <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      n <= {n[npp_pkg::DIV_NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, d}) begin
        rem <= rem_sh - {1'b0, d};
        quo <= {quo[npp_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[npp_pkg::DIV_NUM_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == npp_pkg::DIV_CNT_W'(npp_pkg::DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/npp_datapath.sv
// Datapath: vertex store, edge multipliers, accumulators, normalization,
// square root and divider, and the result registers.
// Depends on npp_pkg, npp_sqrt and npp_div.
module npp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  npp_pkg::cmd_t                        cmd,
  input  logic signed [npp_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [npp_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [npp_pkg::COORD_W-1:0]   coord_z,
  input  logic [npp_pkg::CFG_DATA_W-1:0]       min_len,
  output npp_pkg::sts_t                        sts,
  output logic [1:0]                           status,
  output logic signed [npp_pkg::NORM_W-1:0]    normal_x,
  output logic signed [npp_pkg::NORM_W-1:0]    normal_y,
  output logic signed [npp_pkg::NORM_W-1:0]    normal_z,
  output logic signed [npp_pkg::OFF_W-1:0]     plane_offset
);

  logic signed [npp_pkg::COORD_W-1:0] in_v  [3];
  logic signed [npp_pkg::COORD_W-1:0] cur   [3];
  logic signed [npp_pkg::COORD_W-1:0] first [3];
  logic signed [npp_pkg::COORD_W-1:0] prev  [3];
  logic signed [npp_pkg::COORD_W-1:0] pb    [3];
  logic signed [npp_pkg::COORD_W:0]   dif   [3];
  logic signed [npp_pkg::COORD_W:0]   smm   [3];
  logic signed [npp_pkg::ACC_W-1:0]   acc   [3];
  logic signed [npp_pkg::SUM_W-1:0]   sums  [3];
  logic signed [npp_pkg::MUL_W-1:0]   ma    [3];
  logic signed [npp_pkg::MUL_W-1:0]   mb    [3];
  logic signed [npp_pkg::PROD_W-1:0]  prod  [3];
  logic [npp_pkg::ACC_W-1:0]          mag   [3];
  logic signed [npp_pkg::NORM_W-1:0]  u     [3];
  logic [npp_pkg::CNT_W-1:0]          count;
  logic                               ovf;
  logic [npp_pkg::SHIFT_W-1:0]        shamt;
  logic [npp_pkg::SQ_W-1:0]           sq;
  logic [npp_pkg::ROOT_W-1:0]         root;
  logic                               sqrt_done;
  logic [npp_pkg::ACC_W+1:0]          len_shifted;
  logic [1:0]                         code;
  logic signed [npp_pkg::DOT_W-1:0]   dot;
  logic [npp_pkg::DOT_W-1:0]          dot_mag;
  logic [npp_pkg::DIV_NUM_W-1:0]      off_num;
  logic                               off_neg;
  logic [npp_pkg::DIV_DEN_W-1:0]      off_den;
  logic [npp_pkg::DIV_NUM_W-1:0]      div_num;
  logic [npp_pkg::DIV_DEN_W-1:0]      div_den;
  logic [npp_pkg::DIV_NUM_W-1:0]      quo;
  logic                               div_done;
  logic [npp_pkg::NORM_W-1:0]         qn;
  logic [npp_pkg::OFF_W-1:0]          qo;

  assign in_v[0] = coord_x;
  assign in_v[1] = coord_y;
  assign in_v[2] = coord_z;

  // Edge from the previous vertex to either the incoming one or the first one.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pb[k] = cmd.take_edge ? in_v[k] : first[k];
    end
    dif[0] = (npp_pkg::COORD_W+1)'(prev[1]) - (npp_pkg::COORD_W+1)'(pb[1]);
    smm[0] = (npp_pkg::COORD_W+1)'(prev[2]) + (npp_pkg::COORD_W+1)'(pb[2]);
    dif[1] = (npp_pkg::COORD_W+1)'(prev[2]) - (npp_pkg::COORD_W+1)'(pb[2]);
    smm[1] = (npp_pkg::COORD_W+1)'(prev[0]) + (npp_pkg::COORD_W+1)'(pb[0]);
    dif[2] = (npp_pkg::COORD_W+1)'(prev[0]) - (npp_pkg::COORD_W+1)'(pb[0]);
    smm[2] = (npp_pkg::COORD_W+1)'(prev[1]) + (npp_pkg::COORD_W+1)'(pb[1]);
    for (int k = 0; k < 3; k++) begin
      if (cmd.sq_mul) begin
        ma[k] = $signed({2'b00, mag[k][npp_pkg::MAG_KEEP-1:0]});
        mb[k] = $signed({2'b00, mag[k][npp_pkg::MAG_KEEP-1:0]});
      end else if (cmd.off_mul) begin
        ma[k] = sums[k];
        mb[k] = npp_pkg::MUL_W'(u[k]);
      end else begin
        ma[k] = npp_pkg::MUL_W'(dif[k]);
        mb[k] = npp_pkg::MUL_W'(smm[k]);
      end
    end
  end

  always_comb begin
    dot = $signed(prod[0][npp_pkg::DOT_W-1:0]) + $signed(prod[1][npp_pkg::DOT_W-1:0])
        + $signed(prod[2][npp_pkg::DOT_W-1:0]);
    dot_mag = dot[npp_pkg::DOT_W-1] ? npp_pkg::DOT_W'(-dot) : npp_pkg::DOT_W'(dot);
    off_den = npp_pkg::DIV_DEN_W'({count, npp_pkg::UNIT_SHIFT'(0)});
  end

  always_comb begin
    len_shifted = (npp_pkg::ACC_W+2)'(root) << shamt;
    if (count < npp_pkg::CNT_W'(npp_pkg::MIN_VERTICES)) begin
      code = npp_pkg::STATUS_FEW;
    end else if (ovf) begin
      code = npp_pkg::STATUS_MANY;
    end else if (root == '0 ||
                 len_shifted < (npp_pkg::ACC_W+2)'(min_len)) begin
      code = npp_pkg::STATUS_DEGEN;
    end else begin
      code = npp_pkg::STATUS_OK;
    end
  end

  always_comb begin
    if (cmd.odiv_start) begin
      div_num = off_num;
      div_den = off_den;
    end else begin
      div_num = npp_pkg::DIV_NUM_W'({mag[cmd.comp][npp_pkg::MAG_KEEP-1:0],
                                     npp_pkg::UNIT_SHIFT'(0)})
              + npp_pkg::DIV_NUM_W'(root >> 1);
      div_den = root;
    end
    qn = (quo > npp_pkg::DIV_NUM_W'(npp_pkg::UNIT_ONE)) ?
         npp_pkg::NORM_W'(npp_pkg::UNIT_ONE) : quo[npp_pkg::NORM_W-1:0];
    if (off_neg) begin
      qo = (quo > npp_pkg::DIV_NUM_W'(npp_pkg::OFF_NEG_MAG)) ?
           npp_pkg::OFF_W'(-npp_pkg::OFF_NEG_MAG) : npp_pkg::OFF_W'(-quo);
    end else begin
      qo = (quo > npp_pkg::DIV_NUM_W'(npp_pkg::OFF_POS_MAX)) ?
           npp_pkg::OFF_W'(npp_pkg::OFF_POS_MAX) : quo[npp_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.take_init) begin
        count <= npp_pkg::CNT_W'(1);
      end else if (cmd.acc_edge) begin
        count <= count + 1'b1;
      end else if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.take_ovf) begin
        ovf <= 1'b1;
      end else if (cmd.clear) begin
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_edge || cmd.close_mul || cmd.sq_mul || cmd.off_mul) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= npp_pkg::PROD_W'(ma[k]) * npp_pkg::PROD_W'(mb[k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd.take_init) begin
        first[k] <= in_v[k];
        prev[k]  <= in_v[k];
        sums[k]  <= npp_pkg::SUM_W'(in_v[k]);
        acc[k]   <= '0;
      end
      if (cmd.take_edge) begin
        cur[k] <= in_v[k];
      end
      if (cmd.acc_edge) begin
        acc[k]  <= acc[k] + prod[k][npp_pkg::ACC_W-1:0];
        sums[k] <= sums[k] + npp_pkg::SUM_W'(cur[k]);
        prev[k] <= cur[k];
      end
      if (cmd.close_acc) begin
        acc[k] <= acc[k] + prod[k][npp_pkg::ACC_W-1:0];
      end
      if (cmd.mag_load) begin
        mag[k] <= acc[k][npp_pkg::ACC_W-1] ? npp_pkg::ACC_W'(-acc[k]) : acc[k];
      end else if (cmd.norm_step && sts.norm_busy) begin
        mag[k] <= mag[k] >> 1;
      end
    end
    if (cmd.mag_load) begin
      shamt <= '0;
    end else if (cmd.norm_step && sts.norm_busy) begin
      shamt <= shamt + 1'b1;
    end
    if (cmd.sq_sum) begin
      sq <= prod[0][npp_pkg::SQ_W-1:0] + prod[1][npp_pkg::SQ_W-1:0]
          + prod[2][npp_pkg::SQ_W-1:0];
    end
    if (cmd.decide) begin
      status       <= code;
      u[0]         <= '0;
      u[1]         <= '0;
      u[2]         <= '0;
      plane_offset <= '0;
    end
    if (cmd.ndiv_store) begin
      u[cmd.comp] <= acc[cmd.comp][npp_pkg::ACC_W-1] ? $signed(-qn) : $signed(qn);
    end
    if (cmd.off_sum) begin
      off_neg <= !dot[npp_pkg::DOT_W-1] && (dot != '0);
      off_num <= npp_pkg::DIV_NUM_W'(dot_mag) + npp_pkg::DIV_NUM_W'(off_den >> 1);
    end
    if (cmd.off_store) begin
      plane_offset <= $signed(qo);
    end
  end

  npp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (sq),
    .done     (sqrt_done),
    .root     (root)
  );

  npp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.ndiv_start || cmd.odiv_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    sts.count_zero = (count == '0);
    sts.edge_ok    = (count < npp_pkg::CNT_W'(npp_pkg::MAX_VERTICES)) && !ovf;
    sts.norm_busy  = |((mag[0] | mag[1] | mag[2]) >> npp_pkg::MAG_KEEP);
    sts.sqrt_done  = sqrt_done;
    sts.div_done   = div_done;
    sts.status_ok  = (code == npp_pkg::STATUS_OK);
  end

  assign normal_x = u[0];
  assign normal_y = u[1];
  assign normal_z = u[2];

endmodule

// File: rtl/npp_ctrl.sv
// Controller: sequences vertex accumulation and the closing computation,
// and runs both request handshakes. Depends on npp_pkg.
module npp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          last_vertex,
  output logic          out_valid,
  input  logic          out_stall,
  input  npp_pkg::sts_t sts,
  output npp_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_ACC       = 5'd1;
  localparam logic [4:0] S_CLOSE_MUL = 5'd2;
  localparam logic [4:0] S_CLOSE_ACC = 5'd3;
  localparam logic [4:0] S_MAG       = 5'd4;
  localparam logic [4:0] S_NORM      = 5'd5;
  localparam logic [4:0] S_SQ_MUL    = 5'd6;
  localparam logic [4:0] S_SQ_SUM    = 5'd7;
  localparam logic [4:0] S_SQRT      = 5'd8;
  localparam logic [4:0] S_SQRT_WAIT = 5'd9;
  localparam logic [4:0] S_DECIDE    = 5'd10;
  localparam logic [4:0] S_NDIV      = 5'd11;
  localparam logic [4:0] S_NDIV_WAIT = 5'd12;
  localparam logic [4:0] S_NSTORE    = 5'd13;
  localparam logic [4:0] S_OFF_MUL   = 5'd14;
  localparam logic [4:0] S_OFF_SUM   = 5'd15;
  localparam logic [4:0] S_ODIV      = 5'd16;
  localparam logic [4:0] S_ODIV_WAIT = 5'd17;
  localparam logic [4:0] S_OSTORE    = 5'd18;
  localparam logic [4:0] S_OUT       = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] comp;
  logic [1:0] comp_next;
  logic       last;
  logic       take;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign take      = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    cmd.comp   = comp;
    state_next = state;
    comp_next  = comp;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.count_zero) begin
            cmd.take_init = 1'b1;
            state_next    = last_vertex ? S_CLOSE_MUL : S_IDLE;
          end else if (sts.edge_ok) begin
            cmd.take_edge = 1'b1;
            state_next    = S_ACC;
          end else begin
            cmd.take_ovf = 1'b1;
            state_next   = last_vertex ? S_MAG : S_IDLE;
          end
        end
      end
      S_ACC: begin
        cmd.acc_edge = 1'b1;
        state_next   = last ? S_CLOSE_MUL : S_IDLE;
      end
      S_CLOSE_MUL: begin
        cmd.close_mul = 1'b1;
        state_next    = S_CLOSE_ACC;
      end
      S_CLOSE_ACC: begin
        cmd.close_acc = 1'b1;
        state_next    = S_MAG;
      end
      S_MAG: begin
        cmd.mag_load = 1'b1;
        state_next   = S_NORM;
      end
      S_NORM: begin
        cmd.norm_step = 1'b1;
        if (!sts.norm_busy) begin
          state_next = S_SQ_MUL;
        end
      end
      S_SQ_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        cmd.sq_sum = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        comp_next  = '0;
        state_next = sts.status_ok ? S_NDIV : S_OUT;
      end
      S_NDIV: begin
        cmd.ndiv_start = 1'b1;
        state_next     = S_NDIV_WAIT;
      end
      S_NDIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_NSTORE;
        end
      end
      S_NSTORE: begin
        cmd.ndiv_store = 1'b1;
        if (comp == npp_pkg::LAST_COMP) begin
          state_next = S_OFF_MUL;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = S_NDIV;
        end
      end
      S_OFF_MUL: begin
        cmd.off_mul = 1'b1;
        state_next  = S_OFF_SUM;
      end
      S_OFF_SUM: begin
        cmd.off_sum = 1'b1;
        state_next  = S_ODIV;
      end
      S_ODIV: begin
        cmd.odiv_start = 1'b1;
        state_next     = S_ODIV_WAIT;
      end
      S_ODIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_OSTORE;
        end
      end
      S_OSTORE: begin
        cmd.off_store = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp  <= '0;
    end else begin
      state <= state_next;
      comp  <= comp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      last <= last_vertex;
    end
  end

  // A result and a new request are never open at the same time.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("input open while a result is pending");

  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("block not ready after a result was taken");

  a_acc_after_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> $past(take && !sts.count_zero && sts.edge_ok))
    else $error("edge accumulation without an accepted edge vertex");

  a_sqrt_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |=> !sts.sqrt_done)
    else $error("square root reports done right after start");

endmodule

// File: rtl/newell_polygon_plane_unit.sv
// Newell polygon plane unit: top level with the configuration register.
// in_stall rises while an edge vertex is accumulated and stays low for the first
// vertex and dropped extra vertices that are not the last. After the last vertex,
// normalization shifts, the serial square root and the four serial divisions run
// before out_valid; the divisions are skipped when the status is not ok.
// Reset: synchronous, active high; clears the loop and sets min_normal_length to 1.
module newell_polygon_plane_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [npp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [npp_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [npp_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [npp_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [npp_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [npp_pkg::COORD_W-1:0]   coord_z,
  input  logic                                 last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic signed [npp_pkg::NORM_W-1:0]    normal_x,
  output logic signed [npp_pkg::NORM_W-1:0]    normal_y,
  output logic signed [npp_pkg::NORM_W-1:0]    normal_z,
  output logic signed [npp_pkg::OFF_W-1:0]     plane_offset
);

  logic [npp_pkg::CFG_DATA_W-1:0] min_normal_length;
  npp_pkg::cmd_t                  cmd;
  npp_pkg::sts_t                  sts;

  assign pready = 1'b1;
  assign prdata = (paddr == npp_pkg::REG_MIN_LEN) ? min_normal_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_normal_length <= npp_pkg::CFG_DATA_W'(1);
    end else if (psel && penable && pwrite && paddr == npp_pkg::REG_MIN_LEN) begin
      min_normal_length <= pwdata;
    end
  end

  npp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_vertex (last_vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  npp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .min_len      (min_normal_length),
    .sts          (sts),
    .status       (status),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .plane_offset (plane_offset)
  );

endmodule
